>>> design/trb_pkg.sv
// Shared types and constants for the timestamp reorder buffer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package trb_pkg;

  localparam int DEPTH    = 8;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int STAMP_W  = 63;
  localparam int HANDLE_W = 16;
  localparam int HOLD_W   = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 4;
  localparam int CMP_W    = (CNT_W > HOLD_W) ? CNT_W : HOLD_W;

  localparam logic REQ_PUT    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STALE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE  = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic eval;
    logic commit;
    logic load_out;
  } cmd_t;

endpackage

>>> design/trb_if.sv
// Channel interfaces for the reorder buffer: request, result and config write.
// Depends on trb_pkg.
`timescale 1ns / 1ps

interface trb_req_if;
  import trb_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [STAMP_W-1:0]  stamp;
  logic [HANDLE_W-1:0] frame_handle;
  modport source (output valid, req_type, stamp, frame_handle, input ready);
  modport sink   (input valid, req_type, stamp, frame_handle, output ready);
endinterface

interface trb_rsp_if;
  import trb_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;
  logic                head_valid;
  logic [STAMP_W-1:0]  head_stamp;
  logic [HANDLE_W-1:0] head_handle;
  modport source (output valid, status, entry_count, head_valid, head_stamp, head_handle,
                  input ready);
  modport sink   (input valid, status, entry_count, head_valid, head_stamp, head_handle,
                  output ready);
endinterface

interface trb_cfg_if;
  import trb_pkg::*;
  logic              valid;
  logic              ready;
  logic [HOLD_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> design/trb_ctrl.sv
// Request sequencer for the reorder buffer: accept, compare, commit, result.
// Depends on trb_pkg.
`timescale 1ns / 1ps

module trb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output trb_pkg::cmd_t cmd
);
  import trb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_RES
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    cmd.capture  = in_ready_r && in_valid;
    cmd.eval     = (state_r == S_CMP);
    cmd.commit   = (state_r == S_UPD);
    cmd.load_out = (state_r == S_RES) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_CMP;
            in_ready_r <= 1'b0;
          end
        end
        S_CMP: state_r <= S_UPD;
        S_UPD: state_r <= S_RES;
        S_RES: begin
          // hold the result until the output register frees up
          if (out_free) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

>>> design/trb_dpath.sv
// Datapath of the reorder buffer: sorted slot registers, parallel compare,
// shift-insert and shift-remove, holdback register and result register.
// Depends on trb_pkg.
`timescale 1ns / 1ps

module trb_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  trb_pkg::cmd_t                cmd,
  input  logic                         req_type,
  input  logic [trb_pkg::STAMP_W-1:0]  stamp,
  input  logic [trb_pkg::HANDLE_W-1:0] frame_handle,
  input  logic                         cfg_we,
  input  logic [trb_pkg::HOLD_W-1:0]   cfg_data,
  output logic [trb_pkg::STATUS_W-1:0] status,
  output logic [trb_pkg::COUNT_W-1:0]  entry_count,
  output logic                         head_valid,
  output logic [trb_pkg::STAMP_W-1:0]  head_stamp,
  output logic [trb_pkg::HANDLE_W-1:0] head_handle
);
  import trb_pkg::*;

  logic                req_type_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [STAMP_W-1:0]  slot_stamp_r  [DEPTH];
  logic [HANDLE_W-1:0] slot_handle_r [DEPTH];
  logic [CNT_W-1:0]    count_r;
  logic [STAMP_W-1:0]  last_r;
  logic [HOLD_W-1:0]   hold_r;
  logic [CNT_W-1:0]    pos_r;
  logic [STATUS_W-1:0] status_r;

  logic [STATUS_W-1:0] status_o_r;
  logic [COUNT_W-1:0]  count_o_r;
  logic                head_valid_o_r;
  logic [STAMP_W-1:0]  head_stamp_o_r;
  logic [HANDLE_W-1:0] head_handle_o_r;

  logic [DEPTH-1:0]    lt_vec;
  logic [DEPTH-1:0]    eq_vec;
  logic [CNT_W-1:0]    pos_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic                full;
  logic                head_ok;

  // neighbor taps for the insert and remove shifts
  logic [STAMP_W-1:0]  up_stamp  [DEPTH];
  logic [HANDLE_W-1:0] up_handle [DEPTH];
  logic [STAMP_W-1:0]  dn_stamp  [DEPTH];
  logic [HANDLE_W-1:0] dn_handle [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_tap
    if (g == 0) begin : g_first
      assign up_stamp[g]  = stamp_r;
      assign up_handle[g] = handle_r;
    end else begin : g_mid
      assign up_stamp[g]  = slot_stamp_r[g-1];
      assign up_handle[g] = slot_handle_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign dn_stamp[g]  = slot_stamp_r[g];
      assign dn_handle[g] = slot_handle_r[g];
    end else begin : g_inner
      assign dn_stamp[g]  = slot_stamp_r[g+1];
      assign dn_handle[g] = slot_handle_r[g+1];
    end
  end

  assign full    = (count_r >= CNT_W'(DEPTH));
  assign head_ok = (CMP_W'(count_r) > CMP_W'(hold_r));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt_vec[i] = (CNT_W'(i) < count_r) && (slot_stamp_r[i] < stamp_r);
      eq_vec[i] = (CNT_W'(i) < count_r) && (slot_stamp_r[i] == stamp_r);
    end
    // slots are sorted, so the smaller ones form a prefix
    pos_nxt = CNT_W'($countones(lt_vec));
    if (req_type_r == REQ_REMOVE) begin
      status_nxt = head_ok ? ST_DONE : ST_NONE;
    end else begin
      priority if (full) begin
        status_nxt = ST_FULL;
      end else if (stamp_r <= last_r) begin
        status_nxt = ST_STALE;
      end else if (|eq_vec) begin
        status_nxt = ST_DUP;
      end else begin
        status_nxt = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_r <= req_type;
      stamp_r    <= stamp;
      handle_r   <= frame_handle;
    end
    if (cmd.eval) begin
      pos_r    <= pos_nxt;
      status_r <= status_nxt;
    end
    if (cmd.commit && status_r == ST_DONE) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (req_type_r == REQ_PUT) begin
          if (CNT_W'(i) > pos_r) begin
            slot_stamp_r[i]  <= up_stamp[i];
            slot_handle_r[i] <= up_handle[i];
          end else if (CNT_W'(i) == pos_r) begin
            slot_stamp_r[i]  <= stamp_r;
            slot_handle_r[i] <= handle_r;
          end
        end else begin
          slot_stamp_r[i]  <= dn_stamp[i];
          slot_handle_r[i] <= dn_handle[i];
        end
      end
    end
    if (cmd.load_out) begin
      status_o_r      <= status_r;
      count_o_r       <= COUNT_W'(count_r);
      head_valid_o_r  <= head_ok;
      head_stamp_o_r  <= head_ok ? slot_stamp_r[0] : '0;
      head_handle_o_r <= head_ok ? slot_handle_r[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      last_r  <= '0;
      hold_r  <= '0;
    end else begin
      if (cfg_we) begin
        hold_r <= cfg_data;
      end
      if (cmd.commit && status_r == ST_DONE) begin
        if (req_type_r == REQ_PUT) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          count_r <= count_r - CNT_W'(1);
          last_r  <= slot_stamp_r[0];
        end
      end
    end
  end

  assign status      = status_o_r;
  assign entry_count = count_o_r;
  assign head_valid  = head_valid_o_r;
  assign head_stamp  = head_stamp_o_r;
  assign head_handle = head_handle_o_r;

endmodule

>>> design/timestamp_reorder_buffer_core.sv
// Top level of the timestamp reorder buffer: sequencer plus datapath.
// Depends on trb_pkg, trb_if, trb_ctrl and trb_dpath.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------------
//   in_req   | in  | req_type, stamp, frame_handle
//   out_rsp  | out | status, entry_count, head_valid, head_stamp, head_handle
//   cfg_wr   | in  | data (holdback_count), always ready
//
// Each request goes through these steps: the accepting edge captures it, then parallel
// compare against all slots, slot shift commit and result load; the result is
// registered, and the next request is accepted only after the result load.
// One request is in flight at a time; the result register lets a new request
// be accepted while the previous result still waits on out_rsp.ready.
// A stalled output holds the sequencer in its result step.
// Reset (rst_n low, synchronous) empties the buffer, clears the last removed
// timestamp and sets holdback_count to zero.
`timescale 1ns / 1ps

module timestamp_reorder_buffer_core (
  input  logic      clk,
  input  logic      rst_n,
  trb_req_if.sink   in_req,
  trb_rsp_if.source out_rsp,
  trb_cfg_if.sink   cfg_wr
);
  import trb_pkg::*;

  cmd_t cmd;

  assign cfg_wr.ready = 1'b1;

  trb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  trb_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .req_type     (in_req.req_type),
    .stamp        (in_req.stamp),
    .frame_handle (in_req.frame_handle),
    .cfg_we       (cfg_wr.valid),
    .cfg_data     (cfg_wr.data),
    .status       (out_rsp.status),
    .entry_count  (out_rsp.entry_count),
    .head_valid   (out_rsp.head_valid),
    .head_stamp   (out_rsp.head_stamp),
    .head_handle  (out_rsp.head_handle)
  );

endmodule
